// ----- design/pvt_pkg.sv -----
// Shared types, codes, tables and arithmetic helpers of the polygon vertex transform.
`default_nettype none
package pvt_pkg;

   // Store size default and field widths.
   localparam int MAX_POINTS_DEFAULT = 32;
   localparam int COORD_W = 16;
   localparam int INDEX_W = 5;
   localparam int ANGLE_W = 9;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ADD       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLOSE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ROTATE    = 3'd4;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

   // Selects what the datapath loads into the result register.
   localparam logic [2:0] OUT_NONE   = 3'd0;
   localparam logic [2:0] OUT_ADD    = 3'd1;
   localparam logic [2:0] OUT_REFUSE = 3'd2;
   localparam logic [2:0] OUT_PLAIN  = 3'd3;
   localparam logic [2:0] OUT_EMPTY  = 3'd4;
   localparam logic [2:0] OUT_TRANS  = 3'd5;
   localparam logic [2:0] OUT_ROT    = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       idx_clr;
      logic       idx_inc;
      logic       acc_clr;
      logic       acc_en;
      logic       trig_load;
      logic       div_start;
      logic       div_step;
      logic       sub_en;
      logic       mul_en;
      logic       do_close;
      logic       do_clear;
      logic [2:0] out_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              empty;
      logic              full;
      logic              closed;
      logic              last_idx;
      logic              div_done;
      logic              out_free;
   } stat_type;

   // Quarter-wave sine in Q1.14, one entry per degree.
   localparam logic [14:0] SIN_Q14 [91] = '{
      15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
      15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
      15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
      15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
      15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
      15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
      15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
      15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
      15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
      15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
      15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
      15'd16083, 15'd16135, 15'd16182, 15'd16224, 15'd16262, 15'd16294,
      15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // Sine of a whole-degree angle below 360, folded onto the quarter table.
   function automatic logic signed [15:0] sin_deg(input logic [ANGLE_W-1:0] a);
      logic [6:0]  ix;
      logic        neg;
      if (a <= 9'd90) begin
         ix = a[6:0]; neg = 1'b0;
      end else if (a <= 9'd180) begin
         ix = 7'(9'd180 - a); neg = 1'b0;
      end else if (a <= 9'd270) begin
         ix = 7'(a - 9'd180); neg = 1'b1;
      end else begin
         ix = 7'(9'd360 - a); neg = 1'b1;
      end
      if (neg) return -signed'({1'b0, SIN_Q14[ix]});
      return signed'({1'b0, SIN_Q14[ix]});
   endfunction

   // Saturate a wide signed value to a 16-bit coordinate.
   function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
      if (v > 34'sd32767) return 16'sh7fff;
      if (v < -34'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

endpackage
`default_nettype wire

// ----- design/pvt_ctrl.sv -----
// Controller state machine that sequences requests through the datapath.
`default_nettype none
module pvt_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   output logic              req_tready,
   input  pvt_pkg::stat_type stat,
   output pvt_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_EMIT      = 4'd2;
   localparam logic [3:0] S_TR_RD     = 4'd3;
   localparam logic [3:0] S_TR_WB     = 4'd4;
   localparam logic [3:0] S_TRIG      = 4'd5;
   localparam logic [3:0] S_SUM_RD    = 4'd6;
   localparam logic [3:0] S_SUM_ACC   = 4'd7;
   localparam logic [3:0] S_DIV_START = 4'd8;
   localparam logic [3:0] S_DIV       = 4'd9;
   localparam logic [3:0] S_ROT_RD    = 4'd10;
   localparam logic [3:0] S_ROT_SUB   = 4'd11;
   localparam logic [3:0] S_ROT_MUL   = 4'd12;
   localparam logic [3:0] S_ROT_WB    = 4'd13;

   logic [3:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.idx_clr = 1'b1;
            cmd.acc_clr = 1'b1;
            if (stat.mode == pvt_pkg::MODE_ADD || stat.mode == pvt_pkg::MODE_CLOSE ||
                stat.mode == pvt_pkg::MODE_CLEAR) begin
               state_in = S_EMIT;
            end else if (stat.mode == pvt_pkg::MODE_TRANSLATE ||
                         stat.mode == pvt_pkg::MODE_ROTATE) begin
               if (stat.empty) state_in = S_EMIT;
               else if (stat.mode == pvt_pkg::MODE_TRANSLATE) state_in = S_TR_RD;
               else state_in = S_TRIG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
               case (stat.mode)
                  pvt_pkg::MODE_ADD: begin
                     cmd.out_sel = (stat.full || stat.closed) ? pvt_pkg::OUT_REFUSE
                                                              : pvt_pkg::OUT_ADD;
                  end
                  pvt_pkg::MODE_CLOSE: begin
                     cmd.out_sel  = pvt_pkg::OUT_PLAIN;
                     cmd.do_close = 1'b1;
                  end
                  pvt_pkg::MODE_CLEAR: begin
                     cmd.out_sel  = pvt_pkg::OUT_PLAIN;
                     cmd.do_clear = 1'b1;
                  end
                  default: cmd.out_sel = pvt_pkg::OUT_EMPTY;
               endcase
            end
         end
         S_TR_RD: state_in = S_TR_WB;
         S_TR_WB: begin
            if (stat.out_free) begin
               cmd.out_sel = pvt_pkg::OUT_TRANS;
               if (stat.last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_TR_RD;
               end
            end
         end
         S_TRIG: begin
            cmd.trig_load = 1'b1;
            state_in      = S_SUM_RD;
         end
         S_SUM_RD: state_in = S_SUM_ACC;
         S_SUM_ACC: begin
            cmd.acc_en = 1'b1;
            if (stat.last_idx) begin
               state_in = S_DIV_START;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SUM_RD;
            end
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            cmd.idx_clr   = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_ROT_RD;
            else cmd.div_step = 1'b1;
         end
         S_ROT_RD: state_in = S_ROT_SUB;
         S_ROT_SUB: begin
            cmd.sub_en = 1'b1;
            state_in   = S_ROT_MUL;
         end
         S_ROT_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ROT_WB;
         end
         S_ROT_WB: begin
            if (stat.out_free) begin
               cmd.out_sel = pvt_pkg::OUT_ROT;
               if (stat.last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_ROT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

// ----- design/pvt_dp.sv -----
// Datapath: vertex store, centroid divider, rotation multipliers and result register.
`default_nettype none
module pvt_dp #(
   parameter int MAX_POINTS = pvt_pkg::MAX_POINTS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire  [pvt_pkg::MODE_W-1:0] in_mode,
   input  wire  signed [15:0]         in_px,
   input  wire  signed [15:0]         in_py,
   input  wire  signed [15:0]         in_dx,
   input  wire  signed [15:0]         in_dy,
   input  wire  [pvt_pkg::ANGLE_W-1:0] in_angle,
   input  pvt_pkg::cmd_type           cmd,
   output pvt_pkg::stat_type          stat,
   input  wire                        rsp_tready,
   output logic                       rsp_tvalid,
   output logic [pvt_pkg::STAT_W-1:0] rsp_status,
   output logic [pvt_pkg::INDEX_W-1:0] rsp_index,
   output logic signed [15:0]         rsp_x,
   output logic signed [15:0]         rsp_y,
   output logic                       rsp_last
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = pvt_pkg::COORD_W + CNT_W;
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   // Latched request fields.
   logic [pvt_pkg::MODE_W-1:0]  mode_ff;
   logic signed [15:0]          px_ff, py_ff, dx_ff, dy_ff;
   logic [pvt_pkg::ANGLE_W-1:0] angle_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= in_mode;
         px_ff    <= in_px;
         py_ff    <= in_py;
         dx_ff    <= in_dx;
         dy_ff    <= in_dy;
         angle_ff <= in_angle;
      end
   end

   // Vertex count, closed flag and walk index.
   logic [CNT_W-1:0] count_ff;
   logic             closed_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic signed [15:0] wr_x, wr_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else if (cmd.do_clear) begin
         count_ff  <= '0;
         closed_ff <= 1'b0;
      end else begin
         if (cmd.do_close) closed_ff <= 1'b1;
         if (cmd.out_sel == pvt_pkg::OUT_ADD) count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx_clr) idx_ff <= '0;
      else if (cmd.idx_inc) idx_ff <= idx_ff + 1'b1;
   end

   // Vertex memories with registered read at the walk index.
   logic signed [15:0] mem_x [MAX_POINTS];
   logic signed [15:0] mem_y [MAX_POINTS];
   logic signed [15:0] rd_x_ff, rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      rd_x_ff <= mem_x[idx_ff];
      rd_y_ff <= mem_y[idx_ff];
   end

   // Cosine and sine of the reduced angle.
   logic [pvt_pkg::ANGLE_W-1:0] ang_red, ang_cos;
   logic signed [15:0] cos_ff, sin_ff;

   always_comb begin
      ang_red = (angle_ff >= 9'd360) ? 9'(angle_ff - 9'd360) : angle_ff;
      ang_cos = (ang_red >= 9'd270) ? 9'(ang_red - 9'd270) : 9'(ang_red + 9'd90);
   end

   always_ff @(posedge clock) begin
      if (cmd.trig_load) begin
         sin_ff <= pvt_pkg::sin_deg(ang_red);
         cos_ff <= pvt_pkg::sin_deg(ang_cos);
      end
   end

   // Coordinate sums over the store.
   logic signed [SUM_W-1:0] acc_x_ff, acc_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_x_ff <= acc_x_ff + SUM_W'(rd_x_ff);
         acc_y_ff <= acc_y_ff + SUM_W'(rd_y_ff);
      end
   end

   // Restoring divider, one quotient bit per cycle for both sums.
   logic [SUM_W-1:0]     dvd_x_ff, dvd_y_ff;
   logic [CNT_W-1:0]     rem_x_ff, rem_y_ff;
   logic                 neg_x_ff, neg_y_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [CNT_W:0]       sh_x, sh_y, tr_x, tr_y;
   logic                 ge_x, ge_y;

   always_comb begin
      sh_x = {rem_x_ff, dvd_x_ff[SUM_W-1]};
      sh_y = {rem_y_ff, dvd_y_ff[SUM_W-1]};
      ge_x = sh_x >= {1'b0, count_ff};
      ge_y = sh_y >= {1'b0, count_ff};
      tr_x = sh_x - {1'b0, count_ff};
      tr_y = sh_y - {1'b0, count_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DIV_CNT_W'(SUM_W);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_x_ff <= acc_x_ff[SUM_W-1] ? SUM_W'(-acc_x_ff) : SUM_W'(acc_x_ff);
         dvd_y_ff <= acc_y_ff[SUM_W-1] ? SUM_W'(-acc_y_ff) : SUM_W'(acc_y_ff);
         neg_x_ff <= acc_x_ff[SUM_W-1];
         neg_y_ff <= acc_y_ff[SUM_W-1];
         rem_x_ff <= '0;
         rem_y_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_x_ff <= {dvd_x_ff[SUM_W-2:0], ge_x};
         dvd_y_ff <= {dvd_y_ff[SUM_W-2:0], ge_y};
         rem_x_ff <= ge_x ? tr_x[CNT_W-1:0] : sh_x[CNT_W-1:0];
         rem_y_ff <= ge_y ? tr_y[CNT_W-1:0] : sh_y[CNT_W-1:0];
      end
   end

   // Centroid, truncated toward zero.
   logic signed [16:0] cx, cy, qx, qy;

   always_comb begin
      qx = signed'({1'b0, dvd_x_ff[15:0]});
      qy = signed'({1'b0, dvd_y_ff[15:0]});
      cx = neg_x_ff ? -qx : qx;
      cy = neg_y_ff ? -qy : qy;
   end

   // Coordinates relative to the centroid.
   logic signed [15:0] rel_x_ff, rel_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.sub_en) begin
         rel_x_ff <= pvt_pkg::sat16(34'(rd_x_ff) - 34'(cx));
         rel_y_ff <= pvt_pkg::sat16(34'(rd_y_ff) - 34'(cy));
      end
   end

   // Rotation products.
   logic signed [31:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p_cx_ff <= cos_ff * rel_x_ff;
         p_sy_ff <= sin_ff * rel_y_ff;
         p_sx_ff <= sin_ff * rel_x_ff;
         p_cy_ff <= cos_ff * rel_y_ff;
      end
   end

   // Round, scale by 2^-14 toward zero, saturate and move back.
   logic signed [32:0] num_x, num_y, sc_x, sc_y;
   logic signed [15:0] rot_x, rot_y, new_rx, new_ry, new_tx, new_ty;

   always_comb begin
      num_x  = 33'(p_cx_ff) - 33'(p_sy_ff) + 33'sd8192;
      num_y  = 33'(p_sx_ff) + 33'(p_cy_ff) + 33'sd8192;
      sc_x   = num_x[32] ? (num_x + 33'sd16383) >>> 14 : num_x >>> 14;
      sc_y   = num_y[32] ? (num_y + 33'sd16383) >>> 14 : num_y >>> 14;
      rot_x  = pvt_pkg::sat16(34'(sc_x));
      rot_y  = pvt_pkg::sat16(34'(sc_y));
      new_rx = pvt_pkg::sat16(34'(rot_x) + 34'(cx));
      new_ry = pvt_pkg::sat16(34'(rot_y) + 34'(cy));
      new_tx = pvt_pkg::sat16(34'(rd_x_ff) + 34'(dx_ff));
      new_ty = pvt_pkg::sat16(34'(rd_y_ff) + 34'(dy_ff));
   end

   // Store write port.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_x    = new_tx;
      wr_y    = new_ty;
      case (cmd.out_sel)
         pvt_pkg::OUT_ADD: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[IDX_W-1:0];
            wr_x    = px_ff;
            wr_y    = py_ff;
         end
         pvt_pkg::OUT_TRANS: wr_en = 1'b1;
         pvt_pkg::OUT_ROT: begin
            wr_en = 1'b1;
            wr_x  = new_rx;
            wr_y  = new_ry;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Result register; it frees when the result is taken.
   logic rsp_valid_ff;
   logic is_last;

   assign is_last = (CNT_W'(idx_ff) + 1'b1) == count_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_sel != pvt_pkg::OUT_NONE) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      case (cmd.out_sel)
         pvt_pkg::OUT_ADD: begin
            rsp_status <= pvt_pkg::STAT_OK;
            rsp_index  <= pvt_pkg::INDEX_W'(count_ff);
            rsp_x      <= px_ff;
            rsp_y      <= py_ff;
            rsp_last   <= 1'b1;
         end
         pvt_pkg::OUT_REFUSE, pvt_pkg::OUT_PLAIN, pvt_pkg::OUT_EMPTY: begin
            rsp_status <= (cmd.out_sel == pvt_pkg::OUT_REFUSE) ? pvt_pkg::STAT_REFUSED :
                          (cmd.out_sel == pvt_pkg::OUT_EMPTY)  ? pvt_pkg::STAT_EMPTY :
                                                                 pvt_pkg::STAT_OK;
            rsp_index  <= '0;
            rsp_x      <= '0;
            rsp_y      <= '0;
            rsp_last   <= 1'b1;
         end
         pvt_pkg::OUT_TRANS, pvt_pkg::OUT_ROT: begin
            rsp_status <= pvt_pkg::STAT_OK;
            rsp_index  <= pvt_pkg::INDEX_W'(idx_ff);
            rsp_x      <= wr_x;
            rsp_y      <= wr_y;
            rsp_last   <= is_last;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Status toward the controller.
   always_comb begin
      stat.mode     = mode_ff;
      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff == CNT_W'(MAX_POINTS));
      stat.closed   = closed_ff;
      stat.last_idx = is_last;
      stat.div_done = (div_cnt_ff == '0);
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

   // The count never passes the store size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("vertex count beyond store size");

   // A new result is only loaded when the result register is free.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel != pvt_pkg::OUT_NONE) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // A clear empties the store and reopens the polygon.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.do_clear |=> (count_ff == '0 && !closed_ff))
      else $error("clear did not empty the store");

   // An append is never taken into a full or closed store.
   a_add_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_sel == pvt_pkg::OUT_ADD) |-> (!closed_ff && count_ff < CNT_W'(MAX_POINTS)))
      else $error("append into full or closed store");

endmodule
`default_nettype wire

// ----- design/polygon_vertex_transform.sv -----
// Top level of the polygon vertex store with translate and rotate about centroid.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tdata: mode, px, py, dx, dy, angle
//  rsp     | out       | rsp_tvalid/tready    | tdata: index, x, y; tuser: status; tlast
//
// Add, close and clear pass through dispatch and emit and wait for a free
// result register; translate reads and writes back each vertex in turn;
// rotate runs a summing pass over the store's read port, one divider bit per cycle
// over the sum width, then read, subtract, multiply and write-back per vertex.
// Reset is synchronous and empties and reopens the store at once.
// A stalled result holds the walk; the next request is taken once the
// controller is back in idle, even while the last result still waits.
`default_nettype none
module polygon_vertex_transform #(
   parameter int MAX_POINTS = pvt_pkg::MAX_POINTS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // mode[2:0], px[18:3], py[34:19], dx[50:35], dy[66:51], angle[75:67], zero pad
   input  wire  [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // vertex_index[4:0], vertex_x[20:5], vertex_y[36:21], zero pad
   output logic [39:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   pvt_pkg::cmd_type  cmd;
   pvt_pkg::stat_type stat;

   logic [pvt_pkg::STAT_W-1:0]  rsp_status;
   logic [pvt_pkg::INDEX_W-1:0] rsp_index;
   logic signed [15:0]          rsp_x, rsp_y;

   pvt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pvt_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_mode    (req_tdata[2:0]),
      .in_px      (req_tdata[18:3]),
      .in_py      (req_tdata[34:19]),
      .in_dx      (req_tdata[50:35]),
      .in_dy      (req_tdata[66:51]),
      .in_angle   (req_tdata[75:67]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_index  (rsp_index),
      .rsp_x      (rsp_x),
      .rsp_y      (rsp_y),
      .rsp_last   (rsp_tlast)
   );

   // Pack the result request.
   assign rsp_tdata = {3'b000, rsp_y, rsp_x, rsp_index};
   assign rsp_tuser = rsp_status;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench of the polygon vertex transform block.
`default_nettype none
module tb;

   localparam int NPTS = 32;
   localparam int N_RANDOM = 320;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   polygon_vertex_transform #(.MAX_POINTS(NPTS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   typedef struct packed {
      logic [pvt_pkg::MODE_W-1:0]  mode;
      logic signed [15:0]          px;
      logic signed [15:0]          py;
      logic signed [15:0]          dx;
      logic signed [15:0]          dy;
      logic [pvt_pkg::ANGLE_W-1:0] angle;
   } cmd_item_type;

   typedef struct packed {
      logic [pvt_pkg::STAT_W-1:0]  status;
      logic [pvt_pkg::INDEX_W-1:0] index;
      logic signed [15:0]          x;
      logic signed [15:0]          y;
      logic                        last;
   } vertex_result_type;

   // Directed row: the command plus an optional typed-in result.
   typedef struct {
      cmd_item_type      cmd;
      bit                has_fixed;
      vertex_result_type fixed;
   } directed_row_type;

   vertex_result_type pending_results[$];
   int                pending_fixed[$];
   vertex_result_type fixed_results[$];

   // Shadow polygon state.
   int  shadow_x[NPTS];
   int  shadow_y[NPTS];
   int  shadow_count;
   bit  shadow_closed;

   int  errors = 0;
   int  cycles = 0;
   int  responses = 0;
   int  rotations = 0;
   bit  quiet = 0;

   // Clock generation.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Run guard.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic longint q14_sine(int a);
      int t[91] = '{0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
         2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
         5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
         8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
         10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
         12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
         14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
         15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
         16135, 16182, 16224, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
         16384};
      if (a <= 90) return t[a];
      if (a <= 180) return t[180 - a];
      if (a <= 270) return -t[a - 180];
      return -t[360 - a];
   endfunction

   function automatic vertex_result_type mk(int st, int idx, int x, int y, bit l);
      vertex_result_type r;
      r.status = st[1:0];
      r.index = idx[4:0];
      r.x = x[15:0];
      r.y = y[15:0];
      r.last = l;
      return r;
   endfunction

   // Apply one command to the shadow polygon and queue what it yields.
   task automatic predict_polygon(cmd_item_type c);
      longint sx, sy, cx, cy, cs, sn, x, y, rx, ry;
      int a;
      if (c.mode == pvt_pkg::MODE_ADD) begin
         if (shadow_count < NPTS && !shadow_closed) begin
            shadow_x[shadow_count] = c.px;
            shadow_y[shadow_count] = c.py;
            pending_results.push_back(mk(pvt_pkg::STAT_OK, shadow_count, c.px, c.py, 1));
            shadow_count++;
         end else
            pending_results.push_back(mk(pvt_pkg::STAT_REFUSED, 0, 0, 0, 1));
      end else if (c.mode == pvt_pkg::MODE_CLOSE || c.mode == pvt_pkg::MODE_CLEAR) begin
         if (c.mode == pvt_pkg::MODE_CLOSE) shadow_closed = 1;
         else begin
            shadow_count = 0;
            shadow_closed = 0;
         end
         pending_results.push_back(mk(pvt_pkg::STAT_OK, 0, 0, 0, 1));
      end else if (c.mode == pvt_pkg::MODE_TRANSLATE || c.mode == pvt_pkg::MODE_ROTATE) begin
         if (shadow_count == 0) begin
            pending_results.push_back(mk(pvt_pkg::STAT_EMPTY, 0, 0, 0, 1));
            return;
         end
         if (c.mode == pvt_pkg::MODE_TRANSLATE) begin
            for (int i = 0; i < shadow_count; i++) begin
               shadow_x[i] = clamp16(longint'(shadow_x[i]) + c.dx);
               shadow_y[i] = clamp16(longint'(shadow_y[i]) + c.dy);
            end
         end else begin
            rotations++;
            a = c.angle;
            if (a >= 360) a -= 360;
            sn = q14_sine(a);
            cs = q14_sine(a + 90 >= 360 ? a + 90 - 360 : a + 90);
            sx = 0;
            sy = 0;
            for (int i = 0; i < shadow_count; i++) begin
               sx += shadow_x[i];
               sy += shadow_y[i];
            end
            cx = sx / shadow_count;
            cy = sy / shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               x = clamp16(shadow_x[i] - cx);
               y = clamp16(shadow_y[i] - cy);
               rx = clamp16((cs * x - sn * y + 8192) / 16384);
               ry = clamp16((sn * x + cs * y + 8192) / 16384);
               shadow_x[i] = clamp16(rx + cx);
               shadow_y[i] = clamp16(ry + cy);
            end
         end
         for (int i = 0; i < shadow_count; i++)
            pending_results.push_back(mk(pvt_pkg::STAT_OK, i, shadow_x[i], shadow_y[i],
                                         i == shadow_count - 1));
      end
   endtask

   // Send one request, idling at random before it.
   task automatic send_request(cmd_item_type c);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         gap = $urandom_range(1, 19);
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {4'd0, c.angle, c.dy, c.dx, c.py, c.px, c.mode};
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_polygon(c);
      @(negedge clock);
   endtask

   // Result receiver with random stalls.
   initial begin
      int stall;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 0;
            stall = $urandom_range(1, 19);
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1;
         @(negedge clock);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      vertex_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mk(rsp_tuser, rsp_tdata[4:0], signed'(rsp_tdata[20:5]),
                  signed'(rsp_tdata[36:21]), rsp_tlast);
         responses++;
         if (pending_results.size() == 0) begin
            $error("unexpected result %p", got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (pending_fixed.size() != 0 && pending_fixed[0] == responses) begin
               void'(pending_fixed.pop_front());
               if (fixed_results.pop_front() != want) begin
                  $error("table row disagrees with predictor: %p", want);
                  errors++;
               end
            end
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status); errors++;
            end
            if (got.index !== want.index) begin
               $error("vertex_index expected %0d actual %0d", want.index, got.index);
               errors++;
            end
            if (got.x !== want.x) begin
               $error("vertex_x expected %0d actual %0d", want.x, got.x); errors++;
            end
            if (got.y !== want.y) begin
               $error("vertex_y expected %0d actual %0d", want.y, got.y); errors++;
            end
            if (got.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, got.last); errors++;
            end
         end
      end
   end

   function automatic cmd_item_type mkc(logic [2:0] m, int px, int py, int dx, int dy,
                                        int a);
      cmd_item_type c;
      c.mode = m;
      c.px = px[15:0];
      c.py = py[15:0];
      c.dx = dx[15:0];
      c.dy = dy[15:0];
      c.angle = a[8:0];
      return c;
   endfunction

   function automatic cmd_item_type random_cmd(int shape);
      cmd_item_type c;
      int r;
      c = mkc(pvt_pkg::MODE_ADD, 0, 0, 0, 0, 0);
      c.px = 16'($urandom);
      c.py = 16'($urandom);
      c.dx = 16'($urandom);
      c.dy = 16'($urandom);
      c.angle = 9'($urandom_range(0, 511));
      if ($urandom_range(0, 3) != 0) begin
         c.px = 16'($signed($urandom_range(0, 4000)) - 2000);
         c.py = 16'($signed($urandom_range(0, 4000)) - 2000);
         c.dx = 16'($signed($urandom_range(0, 200)) - 100);
         c.dy = 16'($signed($urandom_range(0, 200)) - 100);
      end
      r = $urandom_range(0, 99);
      if (r < shape) c.mode = pvt_pkg::MODE_ADD;
      else if (r < 70) c.mode = pvt_pkg::MODE_ROTATE;
      else if (r < 82) c.mode = pvt_pkg::MODE_TRANSLATE;
      else if (r < 88) c.mode = pvt_pkg::MODE_CLOSE;
      else if (r < 95) c.mode = pvt_pkg::MODE_CLEAR;
      else c.mode = 3'($urandom_range(5, 7));
      return c;
   endfunction

   initial begin
      directed_row_type rows[$];
      directed_row_type d;
      int drain;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      for (int i = 0; i < NPTS; i++) begin
         shadow_x[i] = 0;
         shadow_y[i] = 0;
      end
      shadow_count = 0;
      shadow_closed = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed table: empty store, extremes, saturation, closed.
      d.has_fixed = 1;
      d.cmd = mkc(pvt_pkg::MODE_TRANSLATE, 0, 0, 5, 5, 0);
      d.fixed = mk(pvt_pkg::STAT_EMPTY, 0, 0, 0, 1);
      rows.push_back(d);
      d.cmd = mkc(pvt_pkg::MODE_ROTATE, 0, 0, 0, 0, 90);
      d.fixed = mk(pvt_pkg::STAT_EMPTY, 0, 0, 0, 1);
      rows.push_back(d);
      d.cmd = mkc(pvt_pkg::MODE_ADD, 32767, -32768, 0, 0, 0);
      d.fixed = mk(pvt_pkg::STAT_OK, 0, 32767, -32768, 1);
      rows.push_back(d);
      d.cmd = mkc(pvt_pkg::MODE_ADD, -32768, 32767, 0, 0, 0);
      d.fixed = mk(pvt_pkg::STAT_OK, 1, -32768, 32767, 1);
      rows.push_back(d);
      d.has_fixed = 0;
      rows.push_back('{mkc(pvt_pkg::MODE_ADD, 100, 200, 0, 0, 0), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_TRANSLATE, 0, 0, 32767, -32768, 0), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_ROTATE, 0, 0, 0, 0, 0), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_ROTATE, 0, 0, 0, 0, 359), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_ROTATE, 0, 0, 0, 0, 511), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_ROTATE, 0, 0, 0, 0, 180), 0, '0});
      rows.push_back('{mkc(3'd7, -1, -1, -1, -1, 511), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_CLOSE, 0, 0, 0, 0, 0), 1,
                       mk(pvt_pkg::STAT_OK, 0, 0, 0, 1)});
      rows.push_back('{mkc(pvt_pkg::MODE_ADD, 1, 1, 0, 0, 0), 1,
                       mk(pvt_pkg::STAT_REFUSED, 0, 0, 0, 1)});
      rows.push_back('{mkc(pvt_pkg::MODE_TRANSLATE, 0, 0, -32768, 32767, 0), 0, '0});
      rows.push_back('{mkc(pvt_pkg::MODE_CLEAR, 0, 0, 0, 0, 0), 1,
                       mk(pvt_pkg::STAT_OK, 0, 0, 0, 1)});
      rows.push_back('{mkc(pvt_pkg::MODE_CLOSE, 0, 0, 0, 0, 0), 1,
                       mk(pvt_pkg::STAT_OK, 0, 0, 0, 1)});
      rows.push_back('{mkc(pvt_pkg::MODE_CLEAR, 0, 0, 0, 0, 0), 1,
                       mk(pvt_pkg::STAT_OK, 0, 0, 0, 1)});
      foreach (rows[k]) begin
         if (rows[k].has_fixed) begin
            pending_fixed.push_back(responses + pending_results.size() + 1);
            fixed_results.push_back(rows[k].fixed);
         end
         send_request(rows[k].cmd);
      end

      // Fill the store to capacity, then one refused add.
      for (int i = 0; i < NPTS + 1; i++)
         send_request(mkc(pvt_pkg::MODE_ADD, $urandom, $urandom, 0, 0, 0));
      send_request(mkc(pvt_pkg::MODE_ROTATE, 0, 0, 0, 0, $urandom_range(0, 359)));
      send_request(mkc(pvt_pkg::MODE_CLEAR, 0, 0, 0, 0, 0));

      // Random part: adds dominate while the polygon is small.
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n > N_RANDOM - 40) quiet = 1;
         send_request(random_cmd(shadow_count < 4 ? 60 : 35));
      end
      req_tvalid <= 0;

      drain = 0;
      while (pending_results.size() != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (300) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         errors++;
      end
      $display("Covered %0d results including %0d rotations,", responses, rotations);
      $display("plus full, closed and empty store cases.");
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
